// ===== src/joystick_axis_conditioner_assert.svh =====
// assertion macros for the checker file jac_checker.sv
`ifndef JOYSTICK_AXIS_CONDITIONER_ASSERT_SVH
`define JOYSTICK_AXIS_CONDITIONER_ASSERT_SVH

// plain property, sampled on the rising clock edge, off while reset is low
`define JAC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication with |=>: ante at this edge, cons at the next one
`define JAC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/jac_pkg.sv =====
package jac_pkg;

  // fixed field widths
  localparam int ChanW   = 3;
  localparam int RegW    = 12;
  localparam int CfgIdxW = 4;
  localparam int QuoW    = 10;    // scaled value 0..1000
  localparam int Axes    = 4;

  // default parameter values
  localparam int NumChannelsDef  = 4;
  localparam int SampleBitsDef   = 12;
  localparam int FractionBitsDef = 16;

  // arithmetic constants
  localparam int FullScale = 1000;
  localparam int MidScale  = 500;
  localparam int Deadband  = 30;
  localparam int CoefNew   = 13107;  // 0.2 in q0.16, the old weight is 65536 minus this
  localparam int CoefW     = 15;     // signed width that holds CoefNew
  localparam int CoefShift = 16;

  typedef enum logic [1:0] {
    AxThrottle = 2'd0,
    AxYaw      = 2'd1,
    AxPitch    = 2'd2,
    AxRoll     = 2'd3
  } axis_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegThrottleLow  = 4'd0,
    RegThrottleHigh = 4'd1,
    RegYawLow       = 4'd2,
    RegYawHigh      = 4'd3,
    RegPitchLow     = 4'd4,
    RegPitchHigh    = 4'd5,
    RegRollLow      = 4'd6,
    RegRollHigh     = 4'd7
  } cfg_reg_e;

  localparam logic [RegW-1:0] LimLoReset [Axes] = '{12'd50, 12'd0, 12'd105, 12'd130};
  localparam logic [RegW-1:0] LimHiReset [Axes] = '{12'd3200, 12'd3200, 12'd2980, 12'd3120};

  typedef struct packed {
    logic [ChanW-1:0] channel;
    logic [RegW-1:0]  raw_sample;
  } in_item_t;

  typedef struct packed {
    logic [QuoW-1:0] axis_value;
    logic            valid_res;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic prep;
    logic div_step;
    logic filt;
    logic mult;
    logic upd;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic invalid;
    logic out_free;
  } sts_t;

endpackage

// ===== src/joystick_axis_conditioner.sv =====
// channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_stall_o  | in_item_i  (channel, raw_sample)
// out     | output    | out_valid_o / out_stall_i | out_item_o (axis_value, valid_res)
// cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// an item for a valid axis passes from accept to a loaded result through a prep
// step, ten steps of the radix-2 divider, the filter, multiply and update steps
// and the load; an item for an invalid axis goes from prep straight to the load
// the next item is taken in the cycle after the result is loaded, never earlier
// reset (async, low) sets the limits to their defaults and every filter to 500.0
// a stalled result holds in the output register; the next item is still accepted,
// and its result waits in the done state until the register frees up
module joystick_axis_conditioner
  import jac_pkg::*;
#(
  parameter int NUM_CHANNELS  = NumChannelsDef,
  parameter int SAMPLE_BITS   = SampleBitsDef,
  parameter int FRACTION_BITS = FractionBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o,
  // limit register writes
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RegW-1:0]    cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: accept, prep, divide, filter, hand off
  jac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // limits, divider, per-axis filter state and the output register
  jac_datapath #(
    .NUM_CHANNELS  (NUM_CHANNELS),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== src/jac_ctrl.sv =====
module jac_ctrl
  import jac_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StPrep,
    StDiv,
    StFilt,
    StMult,
    StUpd,
    StDone
  } state_e;

  localparam int CntW = $clog2(QuoW);

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) state_d = StPrep;
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        state_d    = sts_i.invalid ? StDone : StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CntW'(1);
        if (cnt_q == CntW'(QuoW - 1)) state_d = StFilt;
      end
      StFilt: begin
        cmd_o.filt = 1'b1;
        state_d    = StMult;
      end
      StMult: begin
        cmd_o.mult = 1'b1;
        state_d    = StUpd;
      end
      StUpd: begin
        cmd_o.upd = 1'b1;
        state_d   = StDone;
      end
      StDone: begin
        cmd_o.load_out = sts_i.out_free;
        if (sts_i.out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

// ===== src/jac_datapath.sv =====
module jac_datapath
  import jac_pkg::*;
#(
  parameter int NUM_CHANNELS  = NumChannelsDef,
  parameter int SAMPLE_BITS   = SampleBitsDef,
  parameter int FRACTION_BITS = FractionBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  in_item_t           in_item_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RegW-1:0]    cfg_data_i,
  input  logic               out_stall_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic               out_valid_o,
  output out_item_t          out_item_o
);

  localparam int LimW    = SAMPLE_BITS;
  localparam int ExtW    = (LimW > RegW) ? LimW : RegW;
  localparam int NumW    = LimW + QuoW;
  localparam int SW      = QuoW + FRACTION_BITS;
  localparam int DW      = SW + 1;
  localparam int PW      = DW + CoefW;
  localparam int NumAxes = (NUM_CHANNELS < Axes) ? NUM_CHANNELS : Axes;
  localparam int IdxW    = (NumAxes > 1) ? $clog2(NumAxes) : 1;

  localparam logic [ChanW:0]       NumAxesC = (ChanW + 1)'(NumAxes);
  localparam logic [SW-1:0]        MidQ     = {QuoW'(MidScale), {FRACTION_BITS{1'b0}}};
  localparam logic [SW:0]          Half     = (SW + 1)'(1) << (FRACTION_BITS - 1);
  localparam logic [QuoW-1:0]      DzLo     = QuoW'(MidScale - Deadband);
  localparam logic [QuoW-1:0]      DzHi     = QuoW'(MidScale + Deadband);
  localparam logic signed [CoefW-1:0] CoefNewS = CoefW'(CoefNew);

  function automatic logic [LimW-1:0] fit(input logic [RegW-1:0] v);
    logic [ExtW-1:0] e;
    e = ExtW'(v);
    return e[LimW-1:0];
  endfunction

  // limit registers
  logic [LimW-1:0] lim_lo_q [Axes];
  logic [LimW-1:0] lim_hi_q [Axes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Axes; i++) begin
        lim_lo_q[i] <= fit(LimLoReset[i]);
        lim_hi_q[i] <= fit(LimHiReset[i]);
      end
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegThrottleLow:  lim_lo_q[AxThrottle] <= fit(cfg_data_i);
        RegThrottleHigh: lim_hi_q[AxThrottle] <= fit(cfg_data_i);
        RegYawLow:       lim_lo_q[AxYaw]      <= fit(cfg_data_i);
        RegYawHigh:      lim_hi_q[AxYaw]      <= fit(cfg_data_i);
        RegPitchLow:     lim_lo_q[AxPitch]    <= fit(cfg_data_i);
        RegPitchHigh:    lim_hi_q[AxPitch]    <= fit(cfg_data_i);
        RegRollLow:      lim_lo_q[AxRoll]     <= fit(cfg_data_i);
        RegRollHigh:     lim_hi_q[AxRoll]     <= fit(cfg_data_i);
        default: ;
      endcase
    end
  end

  // item registers
  logic [ChanW-1:0] ch_q;
  logic [LimW-1:0]  raw_q;
  logic [LimW-1:0]  den_q;
  logic [LimW-1:0]  rem_q;
  logic [QuoW-1:0]  quo_q;
  logic             bad_q;
  logic signed [DW-1:0] delta_q;
  logic signed [PW-1:0] prod_q;
  logic [SW-1:0]    res_q;

  logic [SW-1:0] sm_q [NumAxes];

  logic            valid_ch;
  logic [1:0]      ax;
  logic [IdxW-1:0] idx;
  logic [LimW-1:0] lo, hi, clamped, diff;
  logic [NumW-1:0] num;
  logic [LimW:0]   trial;
  logic            ge;
  logic [QuoW-1:0] scaled, dz;
  logic [SW-1:0]   old;
  logic signed [PW-1:0] step, sum;
  logic [SW:0]     rnd;

  assign valid_ch = ({1'b0, ch_q} < NumAxesC);
  assign ax       = ch_q[1:0];
  assign idx      = ch_q[IdxW-1:0];
  assign lo       = lim_lo_q[ax];
  assign hi       = lim_hi_q[ax];
  assign old      = sm_q[idx];

  // clamp and scale the numerator
  always_comb begin
    if (raw_q < lo) clamped = lo;
    else if (raw_q > hi) clamped = hi;
    else clamped = raw_q;
    diff = clamped - lo;
    num  = NumW'(diff) * NumW'(FullScale);
  end

  // one restoring division step, quotient bits shift in from the right
  assign trial = {rem_q, quo_q[QuoW-1]};
  assign ge    = (trial >= {1'b0, den_q});

  // deadband around center
  assign scaled = bad_q ? '0 : quo_q;
  assign dz     = ((scaled > DzLo) && (scaled < DzHi)) ? QuoW'(MidScale) : scaled;

  // new = old + floor(0.2 * (x - old))
  assign step = prod_q >>> CoefShift;
  assign sum  = PW'($signed({1'b0, old})) + step;
  assign rnd  = {1'b0, res_q} + Half;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ch_q  <= in_item_i.channel;
      raw_q <= fit(in_item_i.raw_sample);
    end
    if (cmd_i.prep) begin
      den_q <= hi - lo;
      bad_q <= (hi <= lo);
      rem_q <= num[NumW-1:QuoW];
      quo_q <= num[QuoW-1:0];
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? LimW'(trial - {1'b0, den_q}) : trial[LimW-1:0];
      quo_q <= {quo_q[QuoW-2:0], ge};
    end
    if (cmd_i.filt) begin
      delta_q <= $signed({1'b0, dz, {FRACTION_BITS{1'b0}}}) - $signed({1'b0, old});
    end
    if (cmd_i.mult) begin
      prod_q <= PW'(delta_q) * PW'(CoefNewS);
    end
    if (cmd_i.upd) begin
      res_q <= sum[SW-1:0];
    end
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumAxes; i++) sm_q[i] <= MidQ;
    end else if (cmd_i.upd) begin
      sm_q[idx] <= sum[SW-1:0];
    end
  end

  // output register
  logic      out_valid_q;
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.axis_value <= valid_ch ? rnd[FRACTION_BITS +: QuoW] : '0;
      out_q.valid_res  <= valid_ch;
    end
  end

  assign sts_o.invalid  = !valid_ch;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_item_o     = out_q;

endmodule

// ===== src/jac_checker.sv =====
`include "joystick_axis_conditioner_assert.svh"

module jac_checker
  import jac_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input out_item_t          out_item_o
);

  // a stalled result stays up and unchanged
  `JAC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `JAC_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_item_o), "stalled result changed")

  // an invalid axis reports zero, a valid one stays in range
  `JAC_ASSERT(a_invalid_zero, clk_i, rst_ni, (out_valid_o && !out_item_o.valid_res) |-> (out_item_o.axis_value == '0), "invalid axis gave a nonzero value")
  `JAC_ASSERT(a_range, clk_i, rst_ni, out_valid_o |-> (out_item_o.axis_value <= QuoW'(FullScale)), "axis value above full scale")

  // one item at a time: busy right after an accept
  `JAC_ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "second item taken while busy")

endmodule

bind joystick_axis_conditioner jac_checker u_chk (.*);
